FILE: hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared codes, field widths and controller command type for the deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 9;

  localparam int S_DATA_W = 40;  // op + word, padded to bytes
  localparam int M_DATA_W = 48;  // status + word + occupancy, padded to bytes

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic capture;  // latch the input beat
    logic exec;     // do the operation, start the store read
    logic load;     // move the result into the output register
  } cdq_cmd_t;

endpackage

FILE: hw/rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: capture, execute, load result; owns both handshakes.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output cdq_pkg::cdq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // wait here until the output register can take the result
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Word store, front/back pointers, count and the output register.
// ----------------------------------------------------------------------------
module cdq_datapath #(
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cdq_pkg::cdq_cmd_t              cmd,
  input  logic [cdq_pkg::OP_W-1:0]       operation,
  input  logic signed [cdq_pkg::WORD_W-1:0] push_value,
  output logic [cdq_pkg::STATUS_W-1:0]   status,
  output logic signed [cdq_pkg::WORD_W-1:0] pop_value,
  output logic [cdq_pkg::OCC_W-1:0]      occupancy
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = cdq_pkg::OCC_W;
  localparam int WW = cdq_pkg::WORD_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WW-1:0] word_store [DEPTH];

  logic [cdq_pkg::OP_W-1:0] op_q;
  logic [WW-1:0]            val_q;
  logic [IW-1:0]            front_index;
  logic [IW-1:0]            back_index;
  logic [CW-1:0]            stored_count;

  logic [cdq_pkg::STATUS_W-1:0] st_q;
  logic                         pop_ok_q;
  logic [CW-1:0]                cnt_q;
  logic [WW-1:0]                rd_data;

  logic                         is_push;
  logic                         ok;
  logic [cdq_pkg::STATUS_W-1:0] st;
  logic [IW-1:0]                front_up;
  logic [IW-1:0]                front_dn;
  logic [IW-1:0]                back_up;
  logic [IW-1:0]                back_dn;
  logic [IW-1:0]                addr;
  logic [IW-1:0]                front_next;
  logic [IW-1:0]                back_next;
  logic [CW-1:0]                count_next;

  assign is_push = (op_q == cdq_pkg::OP_PUSH_FRONT) || (op_q == cdq_pkg::OP_PUSH_BACK);

  assign front_up = (front_index == LAST_IDX) ? '0 : front_index + 1'b1;
  assign front_dn = (front_index == '0) ? LAST_IDX : front_index - 1'b1;
  assign back_up  = (back_index == LAST_IDX) ? '0 : back_index + 1'b1;
  assign back_dn  = (back_index == '0) ? LAST_IDX : back_index - 1'b1;

  always_comb begin
    if (is_push && (stored_count == FULL_CNT)) begin
      st = cdq_pkg::ST_FULL;
    end else if (!is_push && (stored_count == '0)) begin
      st = cdq_pkg::ST_EMPTY;
    end else begin
      st = cdq_pkg::ST_DONE;
    end
  end

  assign ok = (st == cdq_pkg::ST_DONE);

  always_comb begin
    front_next = front_index;
    back_next  = back_index;
    addr       = front_index;
    unique case (op_q)
      cdq_pkg::OP_PUSH_FRONT: begin
        addr       = front_up;
        front_next = front_up;
      end
      cdq_pkg::OP_POP_FRONT: begin
        addr       = front_index;
        front_next = front_dn;
      end
      cdq_pkg::OP_PUSH_BACK: begin
        addr      = back_dn;
        back_next = back_dn;
      end
      cdq_pkg::OP_POP_BACK: begin
        addr      = back_index;
        back_next = back_up;
      end
      default: addr = front_index;
    endcase
    if (!ok) begin
      count_next = stored_count;
    end else if (is_push) begin
      count_next = stored_count + 1'b1;
    end else begin
      count_next = stored_count - 1'b1;
    end
  end

  // input capture and per-item result stage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= operation;
      val_q <= push_value;
    end
    if (cmd.exec) begin
      st_q     <= st;
      pop_ok_q <= ok && !is_push;
      cnt_q    <= count_next;
    end
    if (cmd.load) begin
      status    <= st_q;
      pop_value <= pop_ok_q ? rd_data : '0;
      occupancy <= OW'(cnt_q);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index  <= LAST_IDX;
      back_index   <= '0;
      stored_count <= '0;
    end else if (cmd.exec && ok) begin
      front_index  <= front_next;
      back_index   <= back_next;
      stored_count <= count_next;
    end
  end

  // single-port store, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && ok) begin
      if (is_push) begin
        word_store[addr] <= val_q;
      end else begin
        rd_data <= word_store[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one beat per operation. tdata carries the opcode
//   (push front, pop front, push back, pop back) and the word to push.
//   Master channel (m_*): exactly one result beat per operation with the
//   status (done, full, empty), the popped word (zero unless a pop
//   succeeded) and the occupancy after the operation.
//   An operation passes capture, store access and output load before
//   m_tvalid. A new beat is accepted only after the previous result is
//   loaded; the single-port store's registered read sits between the
//   execute and load steps of the sequencer.
//   A stalled receiver holds the result in the output register; the next
//   beat is still accepted and executed, and its result waits until the
//   output register frees. No beat is lost or repeated.
//   Reset (rst, synchronous): empty deque, front pointer at DEPTH-1, back
//   pointer at 0, no result pending. Store contents are not cleared; a pop
//   only ever reads words that were pushed.
//   Occupancy is reported in its low 9 bits.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] operation, [33:2] push_value, [39:34] zero
  input  logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [33:2] pop_value, [42:34] occupancy, [47:43] zero
  output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int OPW = cdq_pkg::OP_W;
  localparam int WW  = cdq_pkg::WORD_W;
  localparam int SW  = cdq_pkg::STATUS_W;
  localparam int OW  = cdq_pkg::OCC_W;
  localparam int PADW = cdq_pkg::M_DATA_W - SW - WW - OW;

  cdq_pkg::cdq_cmd_t cmd;

  logic [SW-1:0]        status;
  logic signed [WW-1:0] pop_value;
  logic [OW-1:0]        occupancy;

  // sequencing and handshakes
  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // store, pointers, count, output register
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (s_tdata[OPW-1:0]),
    .push_value (s_tdata[OPW+WW-1:OPW]),
    .status     (status),
    .pop_value  (pop_value),
    .occupancy  (occupancy)
  );

  assign m_tdata = {{PADW{1'b0}}, occupancy, pop_value, status};

endmodule
